// ----- rtl/core/pptsch_pkg.sv -----
// Shared types and constants for the preemptive priority task scheduler.
`default_nettype none

package pptsch_pkg;

  localparam int unsigned OP_W       = 1;
  localparam int unsigned TASK_ID_W  = 3;
  localparam int unsigned PRIO_IN_W  = 8;
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned CNT_OUT_W  = 4;
  localparam int unsigned HOOK_W     = 2;

  localparam logic [OP_W-1:0] OP_ACTIVATE  = 1'b0;
  localparam logic [OP_W-1:0] OP_TERMINATE = 1'b1;

  localparam int unsigned HOOK_PRE_BIT  = 0;
  localparam int unsigned HOOK_POST_BIT = 1;

  typedef struct packed {
    logic [OP_W-1:0]      opcode;
    logic [TASK_ID_W-1:0] task_id;
    logic [PRIO_IN_W-1:0] task_priority;
    logic                 full_preemptive;
    logic                 in_isr;
  } req_t;

  typedef struct packed {
    logic [RUN_W-1:0]     running_task;
    logic                 switched;
    logic                 first_dispatch;
    logic                 pre_hook;
    logic                 post_hook;
    logic [CNT_OUT_W-1:0] ready_count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCHED,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sched;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pass_req;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pptsch_ctrl.sv -----
// Sequencer for the scheduler: capture, execute, scheduling pass, response.
`default_nettype none

module pptsch_ctrl
  import pptsch_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire dp_sts_t   sts_i,
  output logic           busy_o,
  output ctrl_cmd_t      cmd_o,
  output logic           rsp_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rsp_valid_o = 1'b0;
    busy_o      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.pass_req ? ST_SCHED : ST_RESP;
      end
      ST_SCHED: begin
        cmd_o.sched = 1'b1;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        rsp_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/pptsch_dp.sv -----
// Scheduler datapath: ready list slots, per-task counters and flags, dispatch.
`default_nettype none

module pptsch_dp
  import pptsch_pkg::*;
#(
  parameter int unsigned TASK_COUNT      = 8,
  parameter int unsigned PRIO_BITS       = 8,
  parameter int unsigned MAX_ACTIVATIONS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [HOOK_W-1:0] cfg_wdata_i,
  input  wire req_t              req_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_sts_t                sts_o,
  output rsp_t                   rsp_o
);

  localparam int unsigned IW = $clog2(TASK_COUNT);
  localparam int unsigned TW = $clog2(TASK_COUNT + 1);
  localparam int unsigned CW = $clog2(MAX_ACTIVATIONS + 1);
  localparam logic [TASK_COUNT-1:0] ALL_ONES = '1;

  // request and config
  req_t              req_q;
  logic [HOOK_W-1:0] hook_q;

  // ready list, kept sorted: slot 0 is the head
  logic [IW-1:0]        slot_id_q   [TASK_COUNT];
  logic [IW-1:0]        slot_id_d   [TASK_COUNT];
  logic [PRIO_BITS-1:0] slot_prio_q [TASK_COUNT];
  logic [PRIO_BITS-1:0] slot_prio_d [TASK_COUNT];
  logic                 slot_fp_q   [TASK_COUNT];
  logic                 slot_fp_d   [TASK_COUNT];
  logic [TW-1:0]        size_q;

  // per-task state
  logic [CW-1:0]         cnt_q [TASK_COUNT];
  logic [TASK_COUNT-1:0] queued_q, started_q, ever_q;

  // running task
  logic [TW-1:0]        cur_q;
  logic [PRIO_BITS-1:0] cur_prio_q;
  logic                 cur_fp_q;

  // result flags
  logic sw_q, first_q, pre_q, post_q;

  logic                  id_ok, cur_ok, act_ok, term_ok;
  logic [IW-1:0]         id_idx, cur_idx, cnt_idx;
  logic [PRIO_BITS-1:0]  new_prio;
  logic [CW-1:0]         cnt_rd;
  logic                  last_act, do_insert, do_remove;
  logic [TASK_COUNT-1:0] slot_vld, ge, match, past;
  logic                  list_nonempty, do_disp;
  logic [IW-1:0]         head_id;

  assign id_ok    = (32'(req_q.task_id) < TASK_COUNT);
  assign id_idx   = IW'(req_q.task_id);
  assign new_prio = PRIO_BITS'(req_q.task_priority);
  assign cur_ok   = (cur_q < TW'(TASK_COUNT));
  assign cur_idx  = cur_q[IW-1:0];
  assign act_ok   = (req_q.opcode == OP_ACTIVATE) && id_ok;
  assign term_ok  = (req_q.opcode == OP_TERMINATE) && cur_ok;

  assign sts_o.pass_req = (act_ok || term_ok) && !req_q.in_isr;

  assign cnt_idx   = act_ok ? id_idx : cur_idx;
  assign cnt_rd    = cnt_q[cnt_idx];
  assign last_act  = (cnt_rd <= CW'(1));
  assign do_insert = act_ok && !queued_q[id_idx] && (size_q < TW'(TASK_COUNT));
  assign do_remove = term_ok && last_act && (|match);

  // slot compares: entries at or above the new priority stay in front
  always_comb begin
    for (int k = 0; k < TASK_COUNT; k++) begin
      slot_vld[k] = (TW'(k) < size_q);
      ge[k]       = slot_vld[k] && (slot_prio_q[k] >= new_prio);
      match[k]    = slot_vld[k] && (slot_id_q[k] == cur_idx);
    end
    for (int k = 0; k < TASK_COUNT; k++) begin
      past[k] = |(match & (ALL_ONES >> (TASK_COUNT - 1 - k)));
    end
  end

  // next slot contents: parallel shift down on insert, up on removal
  always_comb begin
    for (int k = 0; k < TASK_COUNT; k++) begin
      slot_id_d[k]   = slot_id_q[k];
      slot_prio_d[k] = slot_prio_q[k];
      slot_fp_d[k]   = slot_fp_q[k];
    end
    if (cmd_i.exec && do_insert) begin
      if (!ge[0]) begin
        slot_id_d[0]   = id_idx;
        slot_prio_d[0] = new_prio;
        slot_fp_d[0]   = req_q.full_preemptive;
      end
      for (int k = 1; k < TASK_COUNT; k++) begin
        if (!ge[k]) begin
          if (ge[k-1]) begin
            slot_id_d[k]   = id_idx;
            slot_prio_d[k] = new_prio;
            slot_fp_d[k]   = req_q.full_preemptive;
          end else begin
            slot_id_d[k]   = slot_id_q[k-1];
            slot_prio_d[k] = slot_prio_q[k-1];
            slot_fp_d[k]   = slot_fp_q[k-1];
          end
        end
      end
    end else if (cmd_i.exec && do_remove) begin
      for (int k = 0; k < TASK_COUNT - 1; k++) begin
        if (past[k]) begin
          slot_id_d[k]   = slot_id_q[k+1];
          slot_prio_d[k] = slot_prio_q[k+1];
          slot_fp_d[k]   = slot_fp_q[k+1];
        end
      end
    end
  end

  // dispatch: idle takes the head, or a strictly more urgent head preempts a full-preemptive running task
  assign head_id       = slot_id_q[0];
  assign list_nonempty = (size_q != '0);
  assign do_disp = list_nonempty &&
                   (!cur_ok || (cur_fp_q && (slot_prio_q[0] > cur_prio_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hook_q    <= '0;
      size_q    <= '0;
      queued_q  <= '0;
      started_q <= '0;
      ever_q    <= '0;
      cur_q     <= TW'(TASK_COUNT);
      sw_q      <= 1'b0;
      first_q   <= 1'b0;
      pre_q     <= 1'b0;
      post_q    <= 1'b0;
      for (int k = 0; k < TASK_COUNT; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        hook_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        sw_q    <= 1'b0;
        first_q <= 1'b0;
        pre_q   <= 1'b0;
        post_q  <= 1'b0;
      end
      if (cmd_i.exec) begin
        if (act_ok) begin
          if (cnt_rd < CW'(MAX_ACTIVATIONS)) begin
            cnt_q[id_idx] <= cnt_rd + 1'b1;
          end
          started_q[id_idx] <= 1'b0;
          if (do_insert) begin
            size_q           <= size_q + 1'b1;
            queued_q[id_idx] <= 1'b1;
          end
        end else if (term_ok) begin
          post_q <= hook_q[HOOK_POST_BIT];
          if (last_act) begin
            cnt_q[cur_idx] <= '0;
            cur_q          <= TW'(TASK_COUNT);
            sw_q           <= 1'b1;
            if (do_remove) begin
              size_q            <= size_q - 1'b1;
              queued_q[cur_idx] <= 1'b0;
            end
          end else begin
            cnt_q[cur_idx] <= cnt_rd - 1'b1;
          end
        end
      end
      if (cmd_i.sched && do_disp) begin
        cur_q           <= TW'(head_id);
        sw_q            <= 1'b1;
        first_q         <= !ever_q[head_id];
        ever_q[head_id] <= 1'b1;
        if (!cur_ok) begin
          started_q[head_id] <= 1'b1;
        end else begin
          pre_q <= hook_q[HOOK_PRE_BIT] && !started_q[cur_idx];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    for (int k = 0; k < TASK_COUNT; k++) begin
      slot_id_q[k]   <= slot_id_d[k];
      slot_prio_q[k] <= slot_prio_d[k];
      slot_fp_q[k]   <= slot_fp_d[k];
    end
    if (cmd_i.sched && do_disp) begin
      cur_prio_q <= slot_prio_q[0];
      cur_fp_q   <= slot_fp_q[0];
    end
  end

  assign rsp_o.running_task   = RUN_W'(cur_q);
  assign rsp_o.switched       = sw_q;
  assign rsp_o.first_dispatch = first_q;
  assign rsp_o.pre_hook       = pre_q;
  assign rsp_o.post_hook      = post_q;
  assign rsp_o.ready_count    = CNT_OUT_W'(size_q);

`ifndef SYNTH
  // the running task always sits in the ready list
  a_cur_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_ok |-> queued_q[cur_idx])
    else $error("running task not in ready list");

  // queued flags and list length agree
  a_size_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(queued_q) == int'(size_q))
    else $error("queued flags disagree with list size");

  // a first dispatch is always a switch
  a_first_sw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> sw_q)
    else $error("first dispatch without switch");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/preemptive_priority_task_scheduler.sv -----
// Top level of the preemptive priority task scheduler.
`default_nettype none

// Fixed-priority preemptive task scheduler. One request per start pulse
// (accepted when start is high and busy is low): activate a task or
// terminate the running one. Each request produces exactly one response on
// rsp_o, flagged by rsp_valid_o for a single cycle; the receiver cannot stall
// it. Sequence: accept edge, an execute state (count/flag update and a
// parallel sorted insert or removal across all list slots), a scheduling
// state when a pass runs (skipped for in_isr, an out-of-range task id or a
// terminate with nothing running), then the response state, after which
// busy drops; no new request is accepted before that. hook_enable can
// be written at any edge through cfg_we_i/cfg_wdata_i; write it only while
// idle. running_task reads TASK_COUNT when no task runs.
module preemptive_priority_task_scheduler
  import pptsch_pkg::*;
#(
  parameter int unsigned TASK_COUNT      = 8,
  parameter int unsigned PRIO_BITS       = 8,
  parameter int unsigned MAX_ACTIVATIONS = 15
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire req_t              req_i,
  output logic                   rsp_valid_o,
  output rsp_t                   rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic [HOOK_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer
  pptsch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sts_i       (sts),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .rsp_valid_o (rsp_valid_o)
  );

  // list, counters and dispatch logic
  pptsch_dp #(
    .TASK_COUNT      (TASK_COUNT),
    .PRIO_BITS       (PRIO_BITS),
    .MAX_ACTIVATIONS (MAX_ACTIVATIONS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
